[rtl/glsten_pkg.sv]
// Shared types, widths and register codes for the grid Laplacian stencil.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package glsten_pkg;

  localparam int MAX_WIDTH_DEF = 32;

  localparam int NODE_W = 32;
  localparam int GW_W   = 6;
  localparam int GH_W   = 16;
  localparam int INV_W  = 32;
  localparam int SUM_W  = 35;
  localparam int MAG_W  = 34;
  localparam int HALF_W = 16;
  localparam int PROD_W = MAG_W + HALF_W;

  typedef logic signed [NODE_W-1:0] node_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_INV_DX_SQ   = 2'd2
  } cfg_reg_t;

  localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = 6'd32;
  localparam logic [GH_W-1:0]  GRID_HEIGHT_RST = 16'd32;
  localparam logic [INV_W-1:0] INV_DX_SQ_RST   = 32'd65536;

  // Which neighbors of the center node lie inside the grid.
  typedef struct packed {
    logic up_ok;
    logic down_ok;
    logic left_ok;
    logic right_ok;
  } nbr_flags_t;

endpackage

`default_nettype wire

[rtl/glsten_cell.sv]
// One column cell of the line buffer chain: holds the previous two rows' values.
// Depends on glsten_pkg.
`default_nettype none

module glsten_cell (
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic             entry,
  input  wire glsten_pkg::node_t a_entry,
  input  wire glsten_pkg::node_t b_entry,
  input  wire glsten_pkg::node_t a_right,
  input  wire glsten_pkg::node_t b_right,
  output glsten_pkg::node_t     a_q,
  output glsten_pkg::node_t     b_q
);
  import glsten_pkg::*;

  node_t a_r;
  node_t b_r;

  // The cell at the last active column takes new data; the others take
  // their right neighbor's, so the chain length follows the grid width.
  always_ff @(posedge clk) begin
    if (shift) begin
      a_r <= entry ? a_entry : a_right;
      b_r <= entry ? b_entry : b_right;
    end
  end

  assign a_q = a_r;
  assign b_q = b_r;

endmodule

`default_nettype wire

[rtl/glsten_scale.sv]
// Scaling pipeline: magnitude, split multiply by 1/dx^2, round and saturate.
// Depends on glsten_pkg.
`default_nettype none

module glsten_scale (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    sum_valid,
  output logic                         sum_ready,
  input  wire glsten_pkg::sum_t        sum_value,
  input  wire logic                    sum_last,
  input  wire logic [glsten_pkg::INV_W-1:0] inv_dx_sq,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output glsten_pkg::node_t            out_value,
  output logic                         out_last
);
  import glsten_pkg::*;

  logic              a_valid_r;
  logic              a_neg_r;
  logic [MAG_W-1:0]  a_mag_r;
  logic              a_last_r;

  logic              b_valid_r;
  logic              b_neg_r;
  logic [PROD_W-1:0] b_hi_r;
  logic [PROD_W-1:0] b_lo_r;
  logic              b_last_r;

  logic              o_valid_r;
  node_t             o_value_r;
  logic              o_last_r;

  logic              take_out;
  logic              b_free;
  logic              a_free;

  logic [MAG_W-1:0]  a_mag_nxt;
  logic [PROD_W:0]   lo_round;
  logic [PROD_W:0]   q_sum;
  node_t             o_value_nxt;

  assign take_out  = !o_valid_r || out_ready;
  assign b_free    = !b_valid_r || take_out;
  assign a_free    = !a_valid_r || (b_free && a_valid_r);
  assign sum_ready = a_free;

  assign a_mag_nxt = sum_value[SUM_W-1] ? MAG_W'(-sum_value) : MAG_W'(sum_value);

  // Round the low partial product to nearest, ties away from zero, on the
  // magnitude, then saturate to the signed Q16.16 range.
  always_comb begin
    lo_round = ((PROD_W + 1)'(b_lo_r) + (PROD_W + 1)'(32'h8000)) >> HALF_W;
    q_sum    = (PROD_W + 1)'(b_hi_r) + lo_round;
    if (b_neg_r) begin
      if (q_sum >= (PROD_W + 1)'(64'h8000_0000)) begin
        o_value_nxt = node_t'(32'h8000_0000);
      end else begin
        o_value_nxt = node_t'(32'd0 - q_sum[NODE_W-1:0]);
      end
    end else begin
      if (q_sum > (PROD_W + 1)'(64'h7FFF_FFFF)) begin
        o_value_nxt = node_t'(32'h7FFF_FFFF);
      end else begin
        o_value_nxt = node_t'(q_sum[NODE_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_r <= sum_valid;
      end
      if (b_free) begin
        b_valid_r <= a_valid_r;
      end
      if (take_out) begin
        o_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && sum_valid) begin
      a_neg_r  <= sum_value[SUM_W-1];
      a_mag_r  <= a_mag_nxt;
      a_last_r <= sum_last;
    end
    if (b_free && a_valid_r) begin
      b_neg_r  <= a_neg_r;
      b_hi_r   <= PROD_W'(a_mag_r) * PROD_W'(inv_dx_sq[INV_W-1:HALF_W]);
      b_lo_r   <= PROD_W'(a_mag_r) * PROD_W'(inv_dx_sq[HALF_W-1:0]);
      b_last_r <= a_last_r;
    end
    if (take_out && b_valid_r) begin
      o_value_r <= o_value_nxt;
      o_last_r  <= b_last_r;
    end
  end

  assign out_valid = o_valid_r;
  assign out_value = o_value_r;
  assign out_last  = o_last_r;

endmodule

`default_nettype wire

[rtl/grid_laplacian_stencil_top.sv]
// Top level of the streaming five-point Laplacian with zero-flux edges.
// Depends on glsten_pkg, glsten_cell and glsten_scale.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------
//   in_     | request   | in_valid / in_ready   | in_node_value
//   out_    | result    | out_valid / out_ready | out_laplacian_value, out_frame_last
//   cfg_    | write     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One node is taken per cycle while in_ready is high; the result for the node one
// row up passes the sum register and the scale stages a, b and o. The last node
// of a frame starts a burst, with in_ready low, as the column cells shift out the
// final row. Reset is synchronous and needs no clearing pass: row 0 of every frame
// fills the cells before any read. A stalled output register backs up the pipeline
// one stage at a time; in_ready falls in the burst and when the sum stage is full.
`default_nettype none

module grid_laplacian_stencil_top #(
  parameter int MAX_WIDTH = glsten_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire glsten_pkg::node_t              in_node_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output glsten_pkg::node_t                   out_laplacian_value,
  output logic                                out_frame_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [glsten_pkg::INV_W-1:0]   cfg_data
);
  import glsten_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

  function automatic logic [GW_W-1:0] width_m1(input logic [GW_W-1:0] raw);
    logic [GW_W-1:0] w;
    begin
      w = raw;
      if (raw < GW_W'(2)) begin
        w = GW_W'(2);
      end else if (raw > GW_W'(MAX_WIDTH)) begin
        w = GW_W'(MAX_WIDTH);
      end
      width_m1 = w - GW_W'(1);
    end
  endfunction

  logic [GW_W-1:0]  width_m1_r;
  logic [GH_W-1:0]  height_m1_r;
  logic [INV_W-1:0] inv_r;

  logic [COL_W-1:0] col_r;
  logic [GH_W-1:0]  row_r;
  logic             burst_r;
  logic [COL_W-1:0] burst_col_r;

  node_t            left_r;
  logic             s1_valid_r;
  sum_t             s1_sum_r;
  logic             s1_last_r;

  node_t            a_chain [MAX_WIDTH];
  node_t            b_chain [MAX_WIDTH];

  logic             cfg_fire;
  logic             in_fire;
  logic             s1_ready;
  logic             s1_free;
  logic             burst_issue;
  logic             shift;
  logic             col_end;
  logic             row_end;
  logic             burst_end;
  logic             src_valid;
  logic             src_last;
  nbr_flags_t       flags;
  node_t            down_val;
  sum_t             center_x;
  sum_t             sum_nxt;
  logic [GH_W-1:0]  h_raw;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign s1_free     = !s1_valid_r || s1_ready;
  assign in_ready    = !burst_r && s1_free;
  assign in_fire     = in_valid && in_ready;
  assign burst_issue = burst_r && s1_free;
  assign shift       = in_fire || burst_issue;

  assign col_end   = GW_W'(col_r) == width_m1_r;
  assign row_end   = row_r == height_m1_r;
  assign burst_end = GW_W'(burst_col_r) == width_m1_r;

  // Column cells: cell 0 shows the node one row up, cell 1 its right neighbor.
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    node_t a_right;
    node_t b_right;
    if (i == MAX_WIDTH - 1) begin : g_tail
      assign a_right = in_node_value;
      assign b_right = a_chain[0];
    end else begin : g_mid
      assign a_right = a_chain[i+1];
      assign b_right = b_chain[i+1];
    end
    glsten_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .entry   (width_m1_r == GW_W'(i)),
      .a_entry (in_node_value),
      .b_entry (a_chain[0]),
      .a_right (a_right),
      .b_right (b_right),
      .a_q     (a_chain[i]),
      .b_q     (b_chain[i])
    );
  end

  // During the end-of-frame burst the center row is the last row, so there
  // is no lower neighbor and the upper one always exists.
  always_comb begin
    if (burst_r) begin
      src_valid      = burst_issue;
      src_last       = burst_end;
      flags.up_ok    = 1'b1;
      flags.down_ok  = 1'b0;
      flags.left_ok  = burst_col_r != '0;
      flags.right_ok = !burst_end;
    end else begin
      src_valid      = in_fire && (row_r != '0);
      src_last       = 1'b0;
      flags.up_ok    = row_r > GH_W'(1);
      flags.down_ok  = 1'b1;
      flags.left_ok  = col_r != '0;
      flags.right_ok = !col_end;
    end
    down_val = in_node_value;
    center_x = SUM_W'(a_chain[0]);
    sum_nxt  = '0;
    if (flags.up_ok) begin
      sum_nxt = sum_nxt + (center_x - SUM_W'(b_chain[0]));
    end
    if (flags.down_ok) begin
      sum_nxt = sum_nxt + (center_x - SUM_W'(down_val));
    end
    if (flags.left_ok) begin
      sum_nxt = sum_nxt + (center_x - SUM_W'(left_r));
    end
    if (flags.right_ok) begin
      sum_nxt = sum_nxt + (center_x - SUM_W'(a_chain[1]));
    end
  end

  assign h_raw = cfg_data[GH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_m1_r  <= width_m1(GRID_WIDTH_RST);
      height_m1_r <= GRID_HEIGHT_RST - GH_W'(1);
      inv_r       <= INV_DX_SQ_RST;
      col_r       <= '0;
      row_r       <= '0;
      burst_r     <= 1'b0;
      burst_col_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= src_valid;
      end
      if (burst_issue) begin
        burst_col_r <= burst_col_r + COL_W'(1);
        if (burst_end) begin
          burst_r <= 1'b0;
        end
      end
      if (in_fire) begin
        if (col_end) begin
          col_r <= '0;
          if (row_end) begin
            row_r       <= '0;
            burst_r     <= 1'b1;
            burst_col_r <= '0;
          end else begin
            row_r <= row_r + GH_W'(1);
          end
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (cfg_fire) begin
        case (cfg_index)
          REG_GRID_WIDTH: begin
            width_m1_r <= width_m1(cfg_data[GW_W-1:0]);
            col_r      <= '0;
            row_r      <= '0;
          end
          REG_GRID_HEIGHT: begin
            height_m1_r <= (h_raw < GH_W'(2)) ? GH_W'(1) : h_raw - GH_W'(1);
            col_r       <= '0;
            row_r       <= '0;
          end
          REG_INV_DX_SQ: begin
            inv_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      left_r <= a_chain[0];
    end
    if (s1_free && src_valid) begin
      s1_sum_r  <= sum_nxt;
      s1_last_r <= src_last;
    end
  end

  glsten_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (s1_valid_r),
    .sum_ready (s1_ready),
    .sum_value (s1_sum_r),
    .sum_last  (s1_last_r),
    .inv_dx_sq (inv_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_laplacian_value),
    .out_last  (out_frame_last)
  );

endmodule

`default_nettype wire
